// ===== sv/lcst_pkg.sv =====
// Shared constants and digit arithmetic for the lock code spanning tree block.
package lcst_pkg;

  localparam int MAX_KEYS = 512;
  localparam int IDX_W = $clog2(MAX_KEYS);
  localparam int CNT_W = $clog2(MAX_KEYS + 1);
  localparam int KEY_W = 16;
  localparam int DIGIT_W = 4;
  localparam int DIGITS = 4;
  localparam int DIST_W = 5;
  localparam int TOTAL_W = 14;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
  localparam logic [DIGIT_W-1:0] RADIX = 4'd10;
  localparam logic [DIGIT_W-1:0] HALF_TURN = 4'd5;
  localparam logic [DIST_W-1:0] DIST_NONE = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [DIST_W-1:0] dist_t;

  function automatic key_t clamp_key(input key_t raw);
    key_t out;
    logic [DIGIT_W-1:0] d;
    out = '0;
    for (int s = 0; s < DIGITS; s++) begin
      d = raw[s*DIGIT_W +: DIGIT_W];
      out[s*DIGIT_W +: DIGIT_W] = (d > DIGIT_MAX) ? DIGIT_MAX : d;
    end
    return out;
  endfunction

  function automatic logic [DIGIT_W-1:0] digit_turns(input logic [DIGIT_W-1:0] a,
                                                     input logic [DIGIT_W-1:0] b);
    logic [DIGIT_W-1:0] diff;
    diff = (a > b) ? a - b : b - a;
    return (diff > HALF_TURN) ? RADIX - diff : diff;
  endfunction

  function automatic dist_t zero_dist(input key_t k);
    dist_t sum;
    sum = '0;
    for (int s = 0; s < DIGITS; s++) begin
      sum = sum + DIST_W'(digit_turns('0, k[s*DIGIT_W +: DIGIT_W]));
    end
    return sum;
  endfunction

endpackage

// ===== sv/lcst_dist.sv =====
// Shared distance unit: digit turns between two packed-BCD lock codes.
module lcst_dist (
  input  lcst_pkg::key_t  key_a,
  input  lcst_pkg::key_t  key_b,
  output lcst_pkg::dist_t key_span
);
  import lcst_pkg::*;

  logic [DIGIT_W-1:0] turns [DIGITS];

  always_comb begin
    for (int s = 0; s < DIGITS; s++) begin
      turns[s] = digit_turns(key_a[s*DIGIT_W +: DIGIT_W], key_b[s*DIGIT_W +: DIGIT_W]);
    end
  end

  assign key_span = DIST_W'(turns[0]) + DIST_W'(turns[1]) + DIST_W'(turns[2])
                  + DIST_W'(turns[3]);

endmodule

// ===== sv/lock_code_spanning_tree_length.sv =====
// Top level: key store, dense Prim sequencer and result register.
// Loading takes one key per cycle while the block is in its load state. A set of N keys then
// runs N-1 Prim steps through one distance unit and one read port per memory; a lone key
// goes straight from its root fetch to the result.
// Reset is synchronous, active low, and clears the sequencer, the key count and the result;
// the key and distance memories need no clearing. The next set may load while the result waits.
module lock_code_spanning_tree_length (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] key_code
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [13:0] total_length, [14] overflow, [15] zero
);
  import lcst_pkg::*;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_CAPT  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_TAIL  = 3'd4;
  localparam logic [2:0] S_PICK  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   key_count_r, key_count_nxt;
  logic               ovf_r, ovf_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   pick_r, pick_nxt;
  key_t               pick_key_r, pick_key_nxt;
  logic [CNT_W-1:0]   step_r, step_nxt;
  logic               init_r, init_nxt;
  dist_t              cand_d_r, cand_d_nxt;
  logic [IDX_W-1:0]   cand_idx_r, cand_idx_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               p_vld_r;
  logic [IDX_W-1:0]   p_idx_r;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [TOTAL_W-1:0] out_total_r, out_total_nxt;
  logic               out_ovf_r, out_ovf_nxt;

  key_t               key_mem [MAX_KEYS];
  logic [DIST_W:0]    best_mem [MAX_KEYS];
  key_t               key_rd_r;
  logic [DIST_W:0]    best_rd_r;

  logic               in_acc;
  logic               key_we;
  logic [IDX_W-1:0]   key_raddr;
  logic               best_we;
  logic [IDX_W-1:0]   best_waddr;
  logic [DIST_W:0]    best_wdata;
  logic [CNT_W-1:0]   n_m1;
  dist_t              scan_d;
  dist_t              new_best;
  logic               scan_open;
  dist_t              key_zd;
  logic [TOTAL_W:0]   pick_sum;
  logic [TOTAL_W-1:0] pick_base;

  lcst_dist u_dist (
    .key_a    (pick_key_r),
    .key_b    (key_rd_r),
    .key_span (scan_d)
  );

  assign in_tready  = (state_r == S_LOAD);
  assign in_acc     = in_tvalid && in_tready;
  assign key_we     = in_acc && (key_count_r != CNT_W'(MAX_KEYS));
  assign key_raddr  = (state_r == S_FETCH) ? pick_r : idx_r;
  assign n_m1       = key_count_r - CNT_W'(1);
  assign key_zd     = zero_dist(key_rd_r);

  assign scan_open  = init_r || !best_rd_r[DIST_W];
  assign new_best   = (init_r || scan_d < best_rd_r[DIST_W-1:0]) ? scan_d
                                                                 : best_rd_r[DIST_W-1:0];

  assign pick_base  = total_r;
  assign pick_sum   = {1'b0, pick_base} + (TOTAL_W+1)'(cand_d_r);

  always_comb begin
    best_we    = 1'b0;
    best_waddr = p_idx_r;
    best_wdata = {1'b0, new_best};
    if (state_r == S_PICK) begin
      best_we    = 1'b1;
      best_waddr = cand_idx_r;
      best_wdata = {1'b1, cand_d_r};
    end else if (p_vld_r && scan_open) begin
      best_we    = 1'b1;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    key_count_nxt  = key_count_r;
    ovf_nxt        = ovf_r;
    idx_nxt        = idx_r;
    pick_nxt       = pick_r;
    pick_key_nxt   = pick_key_r;
    step_nxt       = step_r;
    init_nxt       = init_r;
    cand_d_nxt     = cand_d_r;
    cand_idx_nxt   = cand_idx_r;
    total_nxt      = total_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_total_nxt  = out_total_r;
    out_ovf_nxt    = out_ovf_r;

    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (key_we) begin
            key_count_nxt = key_count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            state_nxt = S_FETCH;
            pick_nxt  = '0;
            init_nxt  = 1'b1;
            step_nxt  = '0;
          end
        end
      end
      S_FETCH: begin
        state_nxt = S_CAPT;
      end
      S_CAPT: begin
        pick_key_nxt = key_rd_r;
        cand_d_nxt   = DIST_NONE;
        idx_nxt      = IDX_W'(1);
        if (init_r) begin
          total_nxt = TOTAL_W'(key_zd);
        end
        state_nxt = (key_count_r == CNT_W'(1)) ? S_OUT : S_SCAN;
      end
      S_SCAN: begin
        if (idx_r == n_m1[IDX_W-1:0]) begin
          state_nxt = S_TAIL;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_TAIL: begin
        state_nxt = S_PICK;
      end
      S_PICK: begin
        pick_nxt  = cand_idx_r;
        init_nxt  = 1'b0;
        total_nxt = (pick_sum > (TOTAL_W+1)'(TOTAL_MAX)) ? TOTAL_MAX : pick_sum[TOTAL_W-1:0];
        step_nxt  = step_r + CNT_W'(1);
        state_nxt = (step_r + CNT_W'(1) == n_m1) ? S_OUT : S_FETCH;
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_total_nxt  = total_r;
          out_ovf_nxt    = ovf_r;
          key_count_nxt  = '0;
          ovf_nxt        = 1'b0;
          state_nxt      = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase

    if (p_vld_r) begin
      if (scan_open && new_best < cand_d_r) begin
        cand_d_nxt   = new_best;
        cand_idx_nxt = p_idx_r;
      end
      if (init_r && TOTAL_W'(key_zd) < total_r) begin
        total_nxt = TOTAL_W'(key_zd);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_count_r[IDX_W-1:0]] <= clamp_key(in_tdata);
    end
    key_rd_r <= key_mem[key_raddr];
    if (best_we) begin
      best_mem[best_waddr] <= best_wdata;
    end
    best_rd_r <= best_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      key_count_r  <= '0;
      ovf_r        <= 1'b0;
      init_r       <= 1'b0;
      step_r       <= '0;
      p_vld_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
      total_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      key_count_r  <= key_count_nxt;
      ovf_r        <= ovf_nxt;
      init_r       <= init_nxt;
      step_r       <= step_nxt;
      p_vld_r      <= (state_r == S_SCAN);
      out_tvalid_r <= out_tvalid_nxt;
      total_r      <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    pick_r      <= pick_nxt;
    pick_key_r  <= pick_key_nxt;
    cand_d_r    <= cand_d_nxt;
    cand_idx_r  <= cand_idx_nxt;
    p_idx_r     <= idx_r;
    out_total_r <= out_total_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_ovf_r, out_total_r};

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    key_count_r <= CNT_W'(MAX_KEYS))
    else $error("key count beyond store depth");

  a_scan_skips_root: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r |-> (p_idx_r != '0))
    else $error("scan touched the root entry");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r |-> (CNT_W'(p_idx_r) < key_count_r))
    else $error("scan index beyond loaded keys");

  a_pick_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PICK) |-> (cand_d_r != DIST_NONE))
    else $error("Prim step found no open key");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == S_OUT))
    else $error("result raised outside the output state");
`endif

endmodule
